>>> design/abba_pkg.sv
// Shared types and constants for the aligned bump block allocator.
// No dependencies; used by every design file and the checker.
`default_nettype none

package abba_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  localparam int UID_W       = 31;
  localparam int ADDR_W      = 32;
  localparam int IN_W        = 136;
  localparam int OUT_W       = 72;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_TOTAL  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FAIL    = 3'd1,
    ST_PART    = 3'd2,
    ST_UNKNOWN = 3'd3,
    ST_FULL    = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALIGN,
    S_PLACE,
    S_CHECK,
    S_SCAN,
    S_COMMIT
  } state_e;

  localparam logic [2:0] BT_FIXED      = 3'd2;
  localparam logic [2:0] BT_LOW_ALIGN  = 3'd3;
  localparam logic [2:0] BT_HIGH_ALIGN = 3'd4;

  localparam logic [1:0] CFG_HEAP_BASE = 2'd0;
  localparam logic [1:0] CFG_HEAP_END  = 2'd1;
  localparam logic [1:0] CFG_FIRST_UID = 2'd2;

  localparam logic [31:0] PART_A        = 32'd1;
  localparam logic [31:0] PART_B        = 32'd2;
  localparam logic [31:0] ALIGN_DEFAULT = 32'd256;
  localparam logic [31:0] ALIGN_BAD     = 32'd4096;

  typedef struct packed {
    logic load;
    logic align;
    logic place;
    logic check;
    logic scan;
    logic commit;
  } cmd_t;

  typedef struct packed {
    op_e  in_op;
    logic scan_last;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

>>> design/aligned_bump_block_allocator_unit.sv
// Top level of the aligned bump block allocator: controller plus datapath.
// Depends on abba_pkg, abba_ctrl and abba_dp.
//
//  channel  | direction | words
//  s_axis   | in        | tdata: opcode, partition, alloc_mode, request_size,
//           |           |        place_arg, block_id
//  m_axis   | out       | tdata: status, new_id, value
//  cfg      | in        | index 0 heap_base, 1 heap_end, 2 first_uid
//
// Alloc, free and lookup each run the uid table scan: one entry per cycle through
// the table memory's single read port, plus one compare stage. Total free does not scan.
// Reset clears control state and the entry valid bits; no clearing pass.
// A result waits in the output register; the next word is accepted
// once the block is back in idle, while that result may still be pending.
`default_nettype none

module aligned_bump_block_allocator_unit (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        s_axis_tvalid,
  output logic                       s_axis_tready,
  // [1:0] opcode, [33:2] partition, [36:34] alloc_mode, [68:37] request_size,
  // [100:69] place_arg, [132:101] block_id
  input  wire [abba_pkg::IN_W-1:0]   s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  wire                        m_axis_tready,
  // [2:0] status, [33:3] new_id, [65:34] value
  output logic [abba_pkg::OUT_W-1:0] m_axis_tdata,
  input  wire                        cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire [1:0]                  cfg_index_i,
  input  wire [31:0]                 cfg_data_i
);

  abba_pkg::cmd_t  cmd;
  abba_pkg::stat_t stat;

  assign cfg_ready_o = 1'b1;

  abba_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .stat_i        (stat),
    .cmd_o         (cmd)
  );

  abba_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .s_axis_tdata  (s_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

`default_nettype wire

>>> design/abba_ctrl.sv
// Controller FSM for the allocator: sequences align, place, check, table scan and commit.
// Depends on abba_pkg.
`default_nettype none

module abba_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  s_axis_tvalid,
  output logic                 s_axis_tready,
  input  wire abba_pkg::stat_t stat_i,
  output abba_pkg::cmd_t       cmd_o
);

  abba_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= abba_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      abba_pkg::S_IDLE: begin
        if (s_axis_tvalid) begin
          case (stat_i.in_op)
            abba_pkg::OP_ALLOC:  state_d = abba_pkg::S_ALIGN;
            abba_pkg::OP_FREE:   state_d = abba_pkg::S_SCAN;
            abba_pkg::OP_LOOKUP: state_d = abba_pkg::S_SCAN;
            default:             state_d = abba_pkg::S_COMMIT;
          endcase
        end
      end
      abba_pkg::S_ALIGN: state_d = abba_pkg::S_PLACE;
      abba_pkg::S_PLACE: state_d = abba_pkg::S_CHECK;
      abba_pkg::S_CHECK: state_d = abba_pkg::S_SCAN;
      abba_pkg::S_SCAN: begin
        if (stat_i.scan_last) state_d = abba_pkg::S_COMMIT;
      end
      abba_pkg::S_COMMIT: begin
        if (stat_i.out_free) state_d = abba_pkg::S_IDLE;
      end
      default: state_d = abba_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state_q == abba_pkg::S_IDLE);
    cmd_o.load    = (state_q == abba_pkg::S_IDLE) && s_axis_tvalid;
    cmd_o.align   = (state_q == abba_pkg::S_ALIGN);
    cmd_o.place   = (state_q == abba_pkg::S_PLACE);
    cmd_o.check   = (state_q == abba_pkg::S_CHECK);
    cmd_o.scan    = (state_q == abba_pkg::S_SCAN);
    cmd_o.commit  = (state_q == abba_pkg::S_COMMIT) && stat_i.out_free;
  end

endmodule

`default_nettype wire

>>> design/abba_dp.sv
// Datapath for the allocator: config registers, heap arithmetic, uid table memory,
// scan compare and the output register. Depends on abba_pkg.
`default_nettype none

module abba_dp (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire abba_pkg::cmd_t           cmd_i,
  output abba_pkg::stat_t               stat_o,
  input  wire [abba_pkg::IN_W-1:0]      s_axis_tdata,
  input  wire                           cfg_valid_i,
  input  wire [1:0]                     cfg_index_i,
  input  wire [31:0]                    cfg_data_i,
  output logic                          m_axis_tvalid,
  input  wire                           m_axis_tready,
  output logic [abba_pkg::OUT_W-1:0]    m_axis_tdata
);

  localparam int ENT_W = abba_pkg::UID_W + abba_pkg::ADDR_W;

  // config and heap state
  logic [31:0]                heap_base_q, heap_end_q, heap_next_q;
  logic [abba_pkg::UID_W-1:0] uid_q;

  // captured word
  abba_pkg::op_e              op_q;
  logic                       size_zero_q, part_bad_q, key_neg_q;
  logic [2:0]                 type_q;
  logic [31:0]                size_q, aa_q;
  logic [abba_pkg::UID_W-1:0] key_q;

  // alloc arithmetic
  logic [31:0] mask_q, mask_d, aln_base;
  logic        aln_pow2, is_fixed;
  logic [32:0] addr_q, addr_d, bump_sum;
  logic        below_q, range_fail_q;
  logic [33:0] end_sum;
  logic [31:0] new_next_q;

  // table
  logic [ENT_W-1:0]             tbl_mem [abba_pkg::TABLE_DEPTH];
  logic [ENT_W-1:0]             rd_q;
  logic [abba_pkg::TABLE_DEPTH-1:0] valid_q;
  logic [abba_pkg::CNT_W-1:0]   cnt_q;
  logic                         cmp_v_q;
  logic [abba_pkg::IDX_W-1:0]   rd_idx_q;
  logic                         hit_q, free_q;
  logic [abba_pkg::IDX_W-1:0]   hit_idx_q, free_idx_q;
  logic [31:0]                  hit_addr_q;
  logic                         rd_issue, hit_now, free_now;

  // commit
  abba_pkg::status_e          res_status;
  logic [abba_pkg::UID_W-1:0] res_id;
  logic [31:0]                res_value;
  logic                       wr_en, clr_en;
  logic [abba_pkg::IDX_W-1:0] slot;
  logic [65:0]                out_q;
  logic                       out_v_q;

  assign is_fixed = (type_q == abba_pkg::BT_FIXED);
  assign rd_issue = cmd_i.scan && (cnt_q < abba_pkg::CNT_W'(abba_pkg::TABLE_DEPTH));

  always_comb begin
    stat_o.in_op     = abba_pkg::op_e'(s_axis_tdata[1:0]);
    stat_o.scan_last = cmp_v_q && (rd_idx_q == abba_pkg::IDX_W'(abba_pkg::TABLE_DEPTH - 1));
    stat_o.out_free  = !out_v_q || m_axis_tready;
  end

  // alignment mask
  always_comb begin
    aln_base = (aa_q != 32'd0) ? aa_q : abba_pkg::ALIGN_DEFAULT;
    aln_pow2 = ((aln_base & (aln_base - 32'd1)) == 32'd0);
    if (type_q inside {abba_pkg::BT_LOW_ALIGN, abba_pkg::BT_HIGH_ALIGN}) begin
      mask_d = aln_pow2 ? (aln_base - 32'd1) : (abba_pkg::ALIGN_BAD - 32'd1);
    end else begin
      mask_d = abba_pkg::ALIGN_DEFAULT - 32'd1;
    end
  end

  always_comb begin
    bump_sum = {1'b0, heap_next_q} + {1'b0, mask_q};
    addr_d   = is_fixed ? {1'b0, aa_q} : (bump_sum & ~{1'b0, mask_q});
    end_sum  = {1'b0, addr_q} + {2'b0, size_q};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q        <= abba_pkg::op_e'(s_axis_tdata[1:0]);
      part_bad_q  <= (s_axis_tdata[33:2] != abba_pkg::PART_A) &&
                     (s_axis_tdata[33:2] != abba_pkg::PART_B);
      type_q      <= s_axis_tdata[36:34];
      size_q      <= s_axis_tdata[68:37];
      size_zero_q <= (s_axis_tdata[68:37] == 32'd0);
      aa_q        <= s_axis_tdata[100:69];
      if (abba_pkg::op_e'(s_axis_tdata[1:0]) == abba_pkg::OP_ALLOC) begin
        key_q     <= uid_q;
        key_neg_q <= 1'b0;
      end else begin
        key_q     <= s_axis_tdata[131:101];
        key_neg_q <= s_axis_tdata[132];
      end
    end
    if (cmd_i.align) mask_q <= mask_d;
    if (cmd_i.place) begin
      addr_q  <= addr_d;
      below_q <= aa_q < heap_base_q;
    end
    if (cmd_i.check) begin
      range_fail_q <= (is_fixed && below_q) || (end_sum > {2'b0, heap_end_q});
      new_next_q   <= end_sum[31:0];
    end
  end

  // table memory: one read port during scan, one write at commit
  always_ff @(posedge clk_i) begin
    if (rd_issue) rd_q <= tbl_mem[cnt_q[abba_pkg::IDX_W-1:0]];
    if (wr_en) tbl_mem[slot] <= {key_q, addr_q[31:0]};
  end

  assign hit_now  = cmp_v_q && valid_q[rd_idx_q] && !key_neg_q && !hit_q &&
                    (rd_q[ENT_W-1:abba_pkg::ADDR_W] == key_q);
  assign free_now = cmp_v_q && !valid_q[rd_idx_q] && !free_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      cmp_v_q <= 1'b0;
      hit_q   <= 1'b0;
      free_q  <= 1'b0;
    end else begin
      cmp_v_q <= rd_issue;
      if (cmd_i.load) begin
        cnt_q  <= '0;
        hit_q  <= 1'b0;
        free_q <= 1'b0;
      end else begin
        if (rd_issue) cnt_q <= cnt_q + abba_pkg::CNT_W'(1);
        if (hit_now)  hit_q <= 1'b1;
        if (free_now) free_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_issue) rd_idx_q <= cnt_q[abba_pkg::IDX_W-1:0];
    if (hit_now) begin
      hit_idx_q  <= rd_idx_q;
      hit_addr_q <= rd_q[abba_pkg::ADDR_W-1:0];
    end
    if (free_now) free_idx_q <= rd_idx_q;
  end

  // result and state update
  always_comb begin
    res_status = abba_pkg::ST_OK;
    res_id     = '0;
    res_value  = '0;
    wr_en      = 1'b0;
    clr_en     = 1'b0;
    slot       = hit_q ? hit_idx_q : free_idx_q;
    case (op_q)
      abba_pkg::OP_ALLOC: begin
        if (size_zero_q)              res_status = abba_pkg::ST_FAIL;
        else if (part_bad_q)          res_status = abba_pkg::ST_PART;
        else if (range_fail_q)        res_status = abba_pkg::ST_FAIL;
        else if (!hit_q && !free_q)   res_status = abba_pkg::ST_FULL;
        else begin
          res_id = key_q;
          wr_en  = cmd_i.commit;
        end
      end
      abba_pkg::OP_FREE: begin
        if (hit_q) clr_en = cmd_i.commit;
        else       res_status = abba_pkg::ST_UNKNOWN;
      end
      abba_pkg::OP_LOOKUP: begin
        if (hit_q) res_value = hit_addr_q;
        else       res_status = abba_pkg::ST_UNKNOWN;
      end
      default: begin
        res_value = (heap_next_q <= heap_end_q) ? (heap_end_q - heap_next_q) : 32'd0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_base_q <= '0;
      heap_end_q  <= '0;
      heap_next_q <= '0;
      uid_q       <= abba_pkg::UID_W'(1);
      valid_q     <= '0;
      out_v_q     <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          abba_pkg::CFG_HEAP_BASE: begin
            heap_base_q <= cfg_data_i;
            heap_next_q <= cfg_data_i;
          end
          abba_pkg::CFG_HEAP_END:  heap_end_q <= cfg_data_i;
          abba_pkg::CFG_FIRST_UID: uid_q <= cfg_data_i[abba_pkg::UID_W-1:0];
          default: ;
        endcase
      end
      if (wr_en) begin
        valid_q[slot] <= 1'b1;
        uid_q         <= uid_q + abba_pkg::UID_W'(1);
        if (!is_fixed) heap_next_q <= new_next_q;
      end
      if (clr_en) valid_q[hit_idx_q] <= 1'b0;
      if (cmd_i.commit)       out_v_q <= 1'b1;
      else if (m_axis_tready) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) out_q <= {res_value, res_id, res_status};
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {6'b0, out_q};

endmodule

`default_nettype wire

>>> design/abba_checker.sv
// Port-level checker for the allocator top level, attached by bind.
// Depends on abba_pkg.
`default_nettype none

module abba_checker (
  input wire                        clk_i,
  input wire                        rst_ni,
  input wire                        s_axis_tvalid,
  input wire                        s_axis_tready,
  input wire [abba_pkg::IN_W-1:0]   s_axis_tdata,
  input wire                        m_axis_tvalid,
  input wire                        m_axis_tready,
  input wire [abba_pkg::OUT_W-1:0]  m_axis_tdata,
  input wire                        cfg_valid_i,
  input wire                        cfg_ready_o,
  input wire [1:0]                  cfg_index_i,
  input wire [31:0]                 cfg_data_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while busy");

  a_id_only_on_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[2:0] != 3'(abba_pkg::ST_OK)) |-> m_axis_tdata[33:3] == '0)
    else $error("uid on failed request");

  a_unknown_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[2:0] == 3'(abba_pkg::ST_UNKNOWN)) |->
      m_axis_tdata[65:34] == '0)
    else $error("value on unknown uid");

endmodule

bind aligned_bump_block_allocator_unit abba_checker u_abba_checker (.*);

`default_nettype wire
